// ===== sv/rfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_pkg
// shared types and constants of the frame deframer
// ----------------------------------------------------------------------------
package rfd_pkg;

    localparam int unsigned DEF_MAX_FRAME_LEN = 65535;
    localparam int unsigned FIXED_BYTES       = 24 + 2;
    localparam int unsigned WORD_BYTES        = 4;

    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    localparam logic [7:0] START_MARKER_RST = 8'd2;
    localparam logic [7:0] END_MARKER_RST   = 8'd3;

    typedef enum logic {
        REG_START_MARKER = 1'b0,
        REG_END_MARKER   = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        PH_LEN     = 4'd0,
        PH_IDLEN   = 4'd1,
        PH_ID      = 4'd2,
        PH_MLEN    = 4'd3,
        PH_METHOD  = 4'd4,
        PH_ECODE   = 4'd5,
        PH_ELEN    = 4'd6,
        PH_ETEXT   = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_CSUM    = 4'd9,
        PH_END     = 4'd10,
        PH_HUNT    = 4'd15
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_END = 2'd1,
        ST_LEN_RNG = 2'd2,
        ST_OVERRUN = 2'd3
    } status_t;

    typedef struct packed {
        logic [3:0]         field_kind;
        logic [7:0]         field_byte;
        logic               frame_last;
        status_t            frame_status;
        logic signed [31:0] error_code_value;
    } rfd_result_t;

endpackage
`default_nettype wire

// ===== sv/rfd_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_regs
// apb register file holding the start and end marker bytes
// ----------------------------------------------------------------------------
module rfd_regs
    import rfd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output logic      [7:0]        start_marker,
    output logic      [7:0]        end_marker
);

    logic [7:0] start_reg;
    logic [7:0] end_reg;
    logic       wr_en;
    reg_idx_t   idx;

    assign idx   = reg_idx_t'(paddr[2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= START_MARKER_RST;
            end_reg   <= END_MARKER_RST;
        end else if (wr_en) begin
            case (idx)
                REG_START_MARKER: start_reg <= pwdata[7:0];
                REG_END_MARKER:   end_reg   <= pwdata[7:0];
                default:          start_reg <= start_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_START_MARKER: prdata = {24'd0, start_reg};
            REG_END_MARKER:   prdata = {24'd0, end_reg};
            default:          prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign start_marker = start_reg;
    assign end_marker   = end_reg;

endmodule
`default_nettype wire

// ===== sv/rfd_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_in_stage
// input register for one received byte
// ----------------------------------------------------------------------------
module rfd_in_stage
    import rfd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    output logic            byte_valid,
    output logic [7:0]      byte_data,
    input  wire logic       byte_take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    assign s_ready = !valid_reg || byte_take;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (byte_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= s_data_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule
`default_nettype wire

// ===== sv/rfd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_parser
// frame layout tracker: field phase, byte counter, word assembly, length budget
// ----------------------------------------------------------------------------
module rfd_parser
    import rfd_pkg::*;
#(
    parameter int unsigned MAX_FRAME_LEN = DEF_MAX_FRAME_LEN
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] start_marker,
    input  wire logic [7:0] end_marker,
    input  wire logic       take,
    input  wire logic [7:0] data_byte,
    output logic            produce,
    output rfd_result_t     result
);

    localparam int unsigned LEN_W = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [31:0] MAX_LEN_32 = 32'(MAX_FRAME_LEN);
    localparam logic [31:0] FIXED_32   = 32'(FIXED_BYTES);

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [31:0]        word_reg, word_next;
    logic [31:0]        ecode_reg, ecode_next;
    logic [31:0]        word_in;
    logic               field_done;
    logic [LEN_W-1:0]   rem_after;

    assign word_in    = {word_reg[23:0], data_byte};
    assign field_done = (left_reg == LEN_W'(1));
    assign rem_after  = rem_reg - word_in[LEN_W-1:0];

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        rem_next   = rem_reg;
        word_next  = word_reg;
        ecode_next = ecode_reg;
        produce    = 1'b0;
        result.field_kind       = phase_reg;
        result.field_byte       = data_byte;
        result.frame_last       = 1'b0;
        result.frame_status     = ST_OK;
        result.error_code_value = '0;
        if (take) begin
            case (phase_reg)
                PH_LEN, PH_IDLEN, PH_MLEN, PH_ECODE, PH_ELEN, PH_CSUM: begin
                    produce   = 1'b1;
                    word_next = word_in;
                    left_next = left_reg - LEN_W'(1);
                    if (field_done) begin
                        left_next = LEN_W'(WORD_BYTES);
                        word_next = '0;
                        case (phase_reg)
                            PH_LEN: begin
                                if (word_in < FIXED_32 || word_in > MAX_LEN_32) begin
                                    result.frame_last   = 1'b1;
                                    result.frame_status = ST_LEN_RNG;
                                    phase_next          = PH_HUNT;
                                end else begin
                                    rem_next   = word_in[LEN_W-1:0] - LEN_W'(FIXED_BYTES);
                                    phase_next = PH_IDLEN;
                                end
                            end
                            PH_ECODE: begin
                                ecode_next = word_in;
                                phase_next = PH_ELEN;
                            end
                            PH_CSUM: begin
                                phase_next = PH_END;
                            end
                            default: begin
                                if (word_in > 32'(rem_reg)) begin
                                    result.frame_last   = 1'b1;
                                    result.frame_status = ST_OVERRUN;
                                    phase_next          = PH_HUNT;
                                end else begin
                                    rem_next = rem_after;
                                    if (word_in != '0) begin
                                        left_next = word_in[LEN_W-1:0];
                                    end
                                    case (phase_reg)
                                        PH_IDLEN: phase_next =
                                            (word_in == '0) ? PH_MLEN : PH_ID;
                                        PH_MLEN: phase_next =
                                            (word_in == '0) ? PH_ECODE : PH_METHOD;
                                        default: begin
                                            if (word_in != '0) begin
                                                phase_next = PH_ETEXT;
                                            end else if (rem_after == '0) begin
                                                phase_next = PH_CSUM;
                                            end else begin
                                                phase_next = PH_PAYLOAD;
                                                left_next  = rem_after;
                                            end
                                        end
                                    endcase
                                end
                            end
                        endcase
                        if (result.frame_last) begin
                            result.error_code_value = ecode_reg;
                        end
                    end
                end
                PH_ID, PH_METHOD, PH_ETEXT, PH_PAYLOAD: begin
                    produce   = 1'b1;
                    left_next = left_reg - LEN_W'(1);
                    if (field_done) begin
                        left_next = LEN_W'(WORD_BYTES);
                        word_next = '0;
                        case (phase_reg)
                            PH_ID:     phase_next = PH_MLEN;
                            PH_METHOD: phase_next = PH_ECODE;
                            PH_ETEXT: begin
                                if (rem_reg == '0) begin
                                    phase_next = PH_CSUM;
                                end else begin
                                    phase_next = PH_PAYLOAD;
                                    left_next  = rem_reg;
                                end
                            end
                            default:   phase_next = PH_CSUM;
                        endcase
                    end
                end
                PH_END: begin
                    produce                 = 1'b1;
                    result.frame_last       = 1'b1;
                    result.frame_status     = (data_byte == end_marker) ? ST_OK : ST_BAD_END;
                    result.error_code_value = ecode_reg;
                    phase_next              = PH_HUNT;
                end
                default: begin
                    if (data_byte == start_marker) begin
                        phase_next = PH_LEN;
                        left_next  = LEN_W'(WORD_BYTES);
                        word_next  = '0;
                        ecode_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg  <= left_next;
        rem_reg   <= rem_next;
        word_reg  <= word_next;
        ecode_reg <= ecode_next;
    end

endmodule
`default_nettype wire

// ===== sv/rfd_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_out_stage
// result register toward the downstream item channel
// ----------------------------------------------------------------------------
module rfd_out_stage
    import rfd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  res_valid,
    input  rfd_result_t res_in,
    output logic       res_ready,
    output logic       m_valid,
    input  wire logic  m_ready,
    output rfd_result_t res_out
);

    logic        valid_reg;
    logic        valid_next;
    rfd_result_t res_reg;
    logic        load;

    assign res_ready = !valid_reg || m_ready;
    assign load      = res_valid && res_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

endmodule
`default_nettype wire

// ===== sv/rpc_frame_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpc_frame_deframer
// start/length/end frame deframer, tags each frame byte with its field
// ----------------------------------------------------------------------------
// channel   ports                      direction  carries
// s_        s_valid/s_ready            in         received byte
// m_        m_valid/m_ready            out        tagged byte, last, status, code
// apb       psel/penable/pwrite/paddr  in         start and end marker bytes
//
// one byte per clock sustained while m_ready is high; bytes pass an input
// register, then the phase/counter update and a result register
// hunting bytes and the start marker give no item
// m_ready low holds the result register, then the input register, then s_ready
// synchronous active-low reset puts the parser in hunt and empties both stages
// ----------------------------------------------------------------------------
module rpc_frame_deframer
    import rfd_pkg::*;
#(
    parameter int unsigned MAX_FRAME_LEN = DEF_MAX_FRAME_LEN
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic      [APB_DW-1:0]  prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_data_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [3:0]              m_field_kind,
    output logic [7:0]              m_field_byte,
    output logic                    m_frame_last,
    output logic [1:0]              m_frame_status,
    output logic signed [31:0]      m_error_code_value
);

    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic        byte_valid;
    logic [7:0]  byte_data;
    logic        byte_take;
    logic        produce;
    logic        res_ready;
    rfd_result_t res;
    rfd_result_t res_out;

    rfd_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start_marker (start_marker),
        .end_marker   (end_marker)
    );

    rfd_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data),
        .byte_take   (byte_take)
    );

    assign byte_take = byte_valid && res_ready;

    rfd_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start_marker (start_marker),
        .end_marker   (end_marker),
        .take         (byte_take),
        .data_byte    (byte_data),
        .produce      (produce),
        .result       (res)
    );

    rfd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (produce),
        .res_in    (res),
        .res_ready (res_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .res_out   (res_out)
    );

    assign m_field_kind       = res_out.field_kind;
    assign m_field_byte       = res_out.field_byte;
    assign m_frame_last       = res_out.frame_last;
    assign m_frame_status     = res_out.frame_status;
    assign m_error_code_value = res_out.error_code_value;

endmodule
`default_nettype wire
